// ===== rtl/multi_queue_priority_fifo_assert.svh =====
// assertion macros for the multi queue priority fifo
`ifndef MULTI_QUEUE_PRIORITY_FIFO_ASSERT_SVH
`define MULTI_QUEUE_PRIORITY_FIFO_ASSERT_SVH

// implication checked on every clock edge outside reset
`define MQPF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqpf check failed");

// next-cycle implication
`define MQPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqpf check failed");

`endif

// ===== rtl/mqpf_pkg.sv =====
// shared types and codes of the multi queue priority fifo
`default_nettype none
package mqpf_pkg;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned QSEL_W = 3;
  localparam int unsigned EID_W = 5;
  localparam int unsigned PRIO_W = 8;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PEEK = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_EMPTY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [QSEL_W-1:0] queue_sel;
    logic [EID_W-1:0] entry_id;
    logic [PRIO_W-1:0] priority_req;
  } mqpf_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [EID_W-1:0] entry_out;
    logic [PRIO_W-1:0] priority_out;
    logic is_empty;
  } mqpf_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_LINK,
    S_DONE
  } mqpf_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_start;
    logic walk_step;
    logic commit;
    logic finish;
  } mqpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
  } mqpf_sts_t;
endpackage
`default_nettype wire

// ===== rtl/mqpf_ctrl.sv =====
// sequencer of the multi queue priority fifo
`default_nettype none
module mqpf_ctrl (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic out_stall,
  input wire mqpf_pkg::mqpf_sts_t sts,
  output logic in_stall,
  output logic out_valid,
  output mqpf_pkg::mqpf_cmd_t cmd
);
  import mqpf_pkg::*;

  mqpf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_start = 1'b1;
        state_nxt = sts.need_walk ? S_WALK : S_LINK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_done) state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd.commit = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/mqpf_dp.sv =====
// link tables, walk pointer and result register of the multi queue priority fifo
`default_nettype none
module mqpf_dp #(
  parameter int unsigned POOL_SIZE = 32,
  parameter int unsigned NUM_QUEUES = 8,
  parameter int unsigned PRIO_BITS = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire mqpf_pkg::mqpf_req_t in_req,
  input wire mqpf_pkg::mqpf_cmd_t cmd,
  output mqpf_pkg::mqpf_sts_t sts,
  output mqpf_pkg::mqpf_rsp_t rsp
);
  import mqpf_pkg::*;

  localparam int unsigned IW = $clog2(POOL_SIZE + 1);
  localparam int unsigned AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [IW-1:0] NIL = IW'(POOL_SIZE);

  // small tables held in flops; links, prio and owner are read at several
  // datapath-chosen addresses, and each table is written at up to two
  logic [IW-1:0] nxt_r [POOL_SIZE];
  logic [IW-1:0] prv_r [POOL_SIZE];
  logic [PRIO_BITS-1:0] pri_r [POOL_SIZE];
  logic [QW-1:0] own_r [POOL_SIZE];
  logic [POOL_SIZE-1:0] qd_r;
  logic [IW-1:0] head_r [NUM_QUEUES];
  logic [IW-1:0] tail_r [NUM_QUEUES];

  mqpf_req_t req_r;
  logic [IW-1:0] cur_r;
  logic [$clog2(POOL_SIZE+1)-1:0] steps_r;
  mqpf_rsp_t rsp_r;

  logic qok, eok;
  logic [QW-1:0] qi;
  logic [AW-1:0] ei;
  logic [PRIO_BITS-1:0] pq;
  logic [IW-1:0] hd;
  logic ins_ok;

  always_comb begin
    qok = 32'(req_r.queue_sel) < NUM_QUEUES;
    eok = 32'(req_r.entry_id) < POOL_SIZE;
    qi = QW'(req_r.queue_sel);
    ei = AW'(req_r.entry_id);
    pq = PRIO_BITS'(req_r.priority_req);
    hd = qok ? head_r[qi] : NIL;
    ins_ok = req_r.func == FN_INSERT && qok && eok && !qd_r[ei];
  end

  logic cur_live;
  always_comb begin
    cur_live = cur_r != NIL && 32'(steps_r) < POOL_SIZE
               && pri_r[AW'(cur_r)] >= pq;
    sts.need_walk = ins_ok;
    sts.walk_done = !cur_live;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
    if (cmd.rd_start) begin
      cur_r <= hd;
      steps_r <= '0;
    end else if (cmd.walk_step && cur_live) begin
      cur_r <= nxt_r[AW'(cur_r)];
      steps_r <= steps_r + 1'b1;
    end
  end

  // commit: update tables and form the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qd_r <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
    end else if (cmd.commit) begin
      case (req_r.func)
        FN_INSERT: begin
          if (ins_ok) begin
            pri_r[ei] <= pq;
            own_r[ei] <= qi;
            qd_r[ei] <= 1'b1;
            if (cur_r != NIL) begin
              prv_r[ei] <= prv_r[AW'(cur_r)];
              nxt_r[ei] <= cur_r;
              prv_r[AW'(cur_r)] <= IW'(ei);
              if (prv_r[AW'(cur_r)] != NIL) nxt_r[AW'(prv_r[AW'(cur_r)])] <= IW'(ei);
              else head_r[qi] <= IW'(ei);
            end else begin
              prv_r[ei] <= tail_r[qi];
              nxt_r[ei] <= NIL;
              if (tail_r[qi] != NIL) nxt_r[AW'(tail_r[qi])] <= IW'(ei);
              else head_r[qi] <= IW'(ei);
              tail_r[qi] <= IW'(ei);
            end
          end
        end
        FN_POP, FN_REMOVE: begin
          if ((req_r.func == FN_POP && hd != NIL) ||
              (req_r.func == FN_REMOVE && qok && eok && qd_r[ei] && own_r[ei] == qi)) begin
            logic [AW-1:0] u;
            u = (req_r.func == FN_POP) ? AW'(hd) : ei;
            qd_r[u] <= 1'b0;
            if (prv_r[u] != NIL) nxt_r[AW'(prv_r[u])] <= nxt_r[u];
            else head_r[qi] <= nxt_r[u];
            if (nxt_r[u] != NIL) prv_r[AW'(nxt_r[u])] <= prv_r[u];
            else tail_r[qi] <= prv_r[u];
          end
        end
        default: ;
      endcase
    end
  end

  // result computed in the commit cycle from pre-update state
  logic [IW-1:0] hd_after;
  mqpf_rsp_t rsp_nxt;

  always_comb begin
    logic [AW-1:0] hi;
    hi = AW'(hd);
    rsp_nxt = '0;
    hd_after = hd;
    case (req_r.func)
      FN_INSERT: begin
        if (!qok || !eok) begin
          rsp_nxt.status = ST_MISS;
        end else if (qd_r[ei]) begin
          rsp_nxt.status = ST_DUP;
          rsp_nxt.entry_out = req_r.entry_id;
          rsp_nxt.priority_out = PRIO_W'(pri_r[ei]);
        end else begin
          rsp_nxt.entry_out = req_r.entry_id;
          rsp_nxt.priority_out = PRIO_W'(pq);
          hd_after = IW'(ei);
        end
      end
      FN_PEEK, FN_POP: begin
        if (hd == NIL) begin
          rsp_nxt.status = ST_MISS;
        end else begin
          rsp_nxt.entry_out = EID_W'(hd);
          rsp_nxt.priority_out = PRIO_W'(pri_r[hi]);
          if (req_r.func == FN_POP) hd_after = nxt_r[hi];
        end
      end
      FN_REMOVE: begin
        if (!qok || !eok || !qd_r[ei] || own_r[ei] != qi) begin
          rsp_nxt.status = ST_MISS;
        end else begin
          rsp_nxt.entry_out = req_r.entry_id;
          rsp_nxt.priority_out = PRIO_W'(pri_r[ei]);
          if (prv_r[ei] == NIL) hd_after = nxt_r[ei];
        end
      end
      default: ;
    endcase
    rsp_nxt.is_empty = (hd_after == NIL);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp_r <= rsp_nxt;
  end

  assign rsp = rsp_r;
endmodule
`default_nettype wire

// ===== rtl/multi_queue_priority_fifo.sv =====
// top level of the multi queue priority fifo
// peek, pop, remove, empty test and rejected insert pass from accept through head read and commit to the result
// an accepted insert also walks the list link by link between head read and commit
// a new request is accepted only once the previous result has been taken
// reset: synchronous active low, clears queued flags and all queue heads and tails
// link, priority and owner tables are not reset
`default_nettype none
module multi_queue_priority_fifo #(
  parameter int unsigned POOL_SIZE = 32,
  parameter int unsigned NUM_QUEUES = 8,
  parameter int unsigned PRIO_BITS = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire mqpf_pkg::mqpf_req_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output mqpf_pkg::mqpf_rsp_t out_data
);
  import mqpf_pkg::*;

  mqpf_cmd_t cmd;
  mqpf_sts_t sts;

  // sequencer: accept, read head, walk, commit, present result
  mqpf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_stall(out_stall),
    .sts(sts), .in_stall(in_stall), .out_valid(out_valid), .cmd(cmd)
  );

  // tables and result register
  mqpf_dp #(.POOL_SIZE(POOL_SIZE), .NUM_QUEUES(NUM_QUEUES), .PRIO_BITS(PRIO_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );
endmodule
`default_nettype wire

// ===== rtl/mqpf_checker.sv =====
// port checker for the multi queue priority fifo
`default_nettype none
`include "multi_queue_priority_fifo_assert.svh"
module mqpf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire mqpf_pkg::mqpf_rsp_t out_data
);
  import mqpf_pkg::*;

  `MQPF_ASSERT_IMPL(a_one_side, clk, rst_n, out_valid, in_stall)
  `MQPF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)
  `MQPF_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_data.status != 2'd3)
  `MQPF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

bind multi_queue_priority_fifo mqpf_checker u_mqpf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== tb/multi_queue_priority_fifo_tb.sv =====
// testbench for the multi queue priority fifo: predicted responses checked per transaction
`timescale 1ns / 100ps
`default_nettype none
module multi_queue_priority_fifo_tb;
  import mqpf_pkg::*;

  localparam int unsigned POOL = 32;
  localparam int unsigned NQ = 8;
  localparam int unsigned NIL = POOL;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  mqpf_req_t in_data;
  logic out_valid;
  logic out_stall;
  mqpf_rsp_t out_data;

  multi_queue_priority_fifo u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // shadow copy of the linked lists kept by the block
  int unsigned sh_next[POOL];
  int unsigned sh_prev[POOL];
  logic [7:0] sh_prio[POOL];
  int unsigned sh_owner[POOL];
  bit sh_queued[POOL];
  int unsigned sh_head[NQ];
  int unsigned sh_tail[NQ];

  mqpf_rsp_t pending_rsp_q[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned rsp_count;
  int unsigned idle_cycles;
  bit no_idle;       // long stretch with no bubbles or stalls
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void shadow_unlink(int unsigned q, int unsigned e);
    int unsigned pv;
    int unsigned nx;
    pv = sh_prev[e];
    nx = sh_next[e];
    if (pv < NIL) sh_next[pv] = nx; else sh_head[q] = nx;
    if (nx < NIL) sh_prev[nx] = pv; else sh_tail[q] = pv;
    sh_queued[e] = 1'b0;
  endfunction

  // walk past every entry of equal or higher priority, then splice in
  function automatic void shadow_insert(int unsigned q, int unsigned e, logic [7:0] p);
    int unsigned cur;
    int unsigned pv;
    int unsigned steps;
    cur = sh_head[q];
    steps = 0;
    while (cur < NIL && steps < POOL && sh_prio[cur] >= p) begin
      cur = sh_next[cur];
      steps++;
    end
    sh_prio[e] = p;
    sh_owner[e] = q;
    sh_queued[e] = 1'b1;
    if (cur < NIL) begin
      pv = sh_prev[cur];
      sh_prev[e] = pv;
      sh_next[e] = cur;
      sh_prev[cur] = e;
      if (pv < NIL) sh_next[pv] = e; else sh_head[q] = e;
    end else begin
      sh_prev[e] = sh_tail[q];
      sh_next[e] = NIL;
      if (sh_tail[q] < NIL) sh_next[sh_tail[q]] = e; else sh_head[q] = e;
      sh_tail[q] = e;
    end
  endfunction

  function automatic mqpf_rsp_t predict_response(mqpf_req_t r);
    mqpf_rsp_t rsp;
    int unsigned q;
    int unsigned e;
    int unsigned h;
    q = 32'(r.queue_sel);
    e = 32'(r.entry_id);
    rsp = '0;
    rsp.status = ST_OK;
    case (r.func)
      FN_INSERT: begin
        if (sh_queued[e]) begin
          rsp.status = ST_DUP;
          rsp.entry_out = 5'(e);
          rsp.priority_out = sh_prio[e];
        end else begin
          shadow_insert(q, e, r.priority_req);
          rsp.entry_out = 5'(e);
          rsp.priority_out = r.priority_req;
        end
      end
      FN_PEEK, FN_POP: begin
        if (sh_head[q] >= NIL) begin
          rsp.status = ST_MISS;
        end else begin
          h = sh_head[q];
          rsp.entry_out = 5'(h);
          rsp.priority_out = sh_prio[h];
          if (r.func == FN_POP) shadow_unlink(q, h);
        end
      end
      FN_REMOVE: begin
        if (!sh_queued[e] || sh_owner[e] != q) begin
          rsp.status = ST_MISS;
        end else begin
          rsp.entry_out = 5'(e);
          rsp.priority_out = sh_prio[e];
          shadow_unlink(q, e);
        end
      end
      default: ;  // empty test and unknown codes change nothing
    endcase
    rsp.is_empty = (sh_head[q] >= NIL);
    return rsp;
  endfunction

  // one transaction on the request channel, with random bubbles before it
  task automatic send_request(mqpf_req_t r);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rsp_q.push_back(predict_response(r));
    sent_count++;
  endtask

  task automatic send_fields(logic [2:0] f, int unsigned q, int unsigned e, int unsigned p);
    mqpf_req_t r;
    r.func = f;
    r.queue_sel = 3'(q);
    r.entry_id = 5'(e);
    r.priority_req = 8'(p);
    send_request(r);
  endtask

  // response stall and checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, out_data);
          error_count++;
        end else begin
          mqpf_rsp_t exp_rsp;
          exp_rsp = pending_rsp_q.pop_front();
          rsp_count++;
          if (out_data.status !== exp_rsp.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                     out_data.status);
          if (out_data.entry_out !== exp_rsp.entry_out)
            $display("%0t: entry_out expected %0d actual %0d", $time, exp_rsp.entry_out,
                     out_data.entry_out);
          if (out_data.priority_out !== exp_rsp.priority_out)
            $display("%0t: priority_out expected %0d actual %0d", $time,
                     exp_rsp.priority_out, out_data.priority_out);
          if (out_data.is_empty !== exp_rsp.is_empty)
            $display("%0t: is_empty expected %0d actual %0d", $time, exp_rsp.is_empty,
                     out_data.is_empty);
          if (out_data !== exp_rsp) error_count++;
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 26);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("%0t: watchdog expired, %0d responses outstanding", $time,
               pending_rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // edge values, every code, the miss and duplicate paths
  task automatic test_directed();
    send_fields(FN_PEEK, 0, 0, 0);
    send_fields(FN_POP, 7, 0, 0);
    send_fields(FN_EMPTY, 3, 0, 0);
    send_fields(FN_REMOVE, 2, 31, 0);
    send_fields(FN_INSERT, 0, 0, 8'd0);
    send_fields(FN_INSERT, 0, 31, 8'd255);
    send_fields(FN_INSERT, 0, 5, 8'd255);      // equal priority stays behind
    send_fields(FN_INSERT, 0, 9, 8'd100);
    send_fields(FN_INSERT, 0, 31, 8'd7);       // duplicate insert
    send_fields(FN_INSERT, 7, 9, 8'd1);        // duplicate from another queue
    send_fields(FN_REMOVE, 7, 5, 0);           // wrong owner
    send_fields(FN_PEEK, 0, 0, 0);
    send_fields(FN_REMOVE, 0, 9, 0);           // middle entry
    send_fields(FN_POP, 0, 0, 0);
    send_fields(FN_REMOVE, 0, 0, 0);           // tail entry
    send_fields(FN_POP, 0, 0, 0);
    send_fields(FN_EMPTY, 0, 0, 0);
    send_fields(3'd5, 0, 0, 0);
    send_fields(3'd6, 7, 31, 255);
    send_fields(3'd7, 4, 21, 170);
    send_fields(FN_POP, 0, 0, 0);
  endtask

  function automatic logic [2:0] pick_func();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return FN_INSERT;
    if (r < 52) return FN_PEEK;
    if (r < 72) return FN_POP;
    if (r < 88) return FN_REMOVE;
    if (r < 96) return FN_EMPTY;
    return 3'($urandom_range(7, 5));
  endfunction

  // random traffic on a few queues so that lists grow long
  task automatic test_random(int unsigned count);
    mqpf_req_t r;
    for (int unsigned i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 2);
      r.func = pick_func();
      r.queue_sel = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(2));
      r.entry_id = 5'($urandom);
      case ($urandom_range(3))
        0: r.priority_req = 8'($urandom_range(3));
        1: r.priority_req = 8'($urandom_range(255, 252));
        default: r.priority_req = 8'($urandom);
      endcase
      send_request(r);
    end
    no_idle = 1'b0;
  endtask

  // pop every queue dry
  task automatic test_drain();
    for (int unsigned q = 0; q < NQ; q++) begin
      while (sh_head[q] < NIL) send_fields(FN_POP, q, 0, 0);
      send_fields(FN_EMPTY, q, 0, 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    sent_count = 0;
    rsp_count = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    timed_out = 1'b0;
    for (int i = 0; i < POOL; i++) begin
      sh_queued[i] = 1'b0;
      sh_next[i] = 0;
      sh_prev[i] = 0;
      sh_prio[i] = '0;
      sh_owner[i] = 0;
    end
    for (int i = 0; i < NQ; i++) begin
      sh_head[i] = NIL;
      sh_tail[i] = NIL;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1700);
    test_drain();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * POOL + 10) @(posedge clk);
    $display("covered %0d requests and %0d responses over all five operations,", sent_count,
             rsp_count);
    $display("duplicate inserts, misses, unknown codes and random bubbles and stalls");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
